### src/selectable_checksum_engine_defines.svh
// ---------------------------------------------------------------------------
// Selectable checksum engine assertion macros
// Shared same-cycle and next-cycle implication assertion forms.
// ---------------------------------------------------------------------------
`ifndef SELECTABLE_CHECKSUM_ENGINE_DEFINES_SVH
`define SELECTABLE_CHECKSUM_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CSUM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CSUM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/csum_pkg.sv
// ---------------------------------------------------------------------------
// Checksum engine package
// Algorithm codes, result descriptor, emitter status and start values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package csum_pkg;

  typedef enum logic [3:0] {
    ALG_NONE       = 4'd0,
    ALG_XOR8       = 4'd1,
    ALG_MOD256     = 4'd2,
    ALG_CRC8       = 4'd3,
    ALG_CRC16      = 4'd4,
    ALG_MODBUS     = 4'd5,
    ALG_CCITT      = 4'd6,
    ALG_FLETCHER16 = 4'd7,
    ALG_CRC32      = 4'd8,
    ALG_ADLER32    = 4'd9
  } alg_t;

  localparam logic [16:0] ADLER_MOD    = 17'd65521;
  localparam logic [16:0] FLETCHER_MOD = 17'd255;

  // finished checksum: value, byte count minus one, byte order
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  len;
    logic        little;
  } result_desc_t;

  typedef struct packed {
    logic pend_full;
  } emit_status_t;

  function automatic logic [31:0] start_value(input logic [3:0] sel);
    logic [31:0] v;
    case (sel)
      ALG_CRC8:              v = 32'h0000_00FF;
      ALG_CRC16, ALG_MODBUS: v = 32'h0000_FFFF;
      ALG_CRC32:             v = 32'hFFFF_FFFF;
      ALG_ADLER32:           v = 32'h0000_0001;
      default:               v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

### src/selectable_checksum_engine.sv
// ---------------------------------------------------------------------------
// Selectable checksum engine
// Running checksum over a byte stream under one of nine algorithms, with the
// packed result sent byte by byte when a message closes.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+----------------------
//  in       | in_valid in_ready data_byte has_byte      | one message byte/item
//           | last_byte                                 |
//  out      | out_valid out_ready out_byte out_last     | one checksum byte/item
//           | full_value                                |
//  cfg      | psel penable pwrite paddr pwdata prdata   | algorithm_select, any addr
//           | pready                                    |
//
//  One input item per cycle while in_ready is high; the byte update and result
//  packing are combinational between the accumulator registers and the result register.
//  With an algorithm selected, a closed message yields one to four output items, one per cycle while out_ready is high.
//  in_ready drops only while a second finished result waits in the pending
//  slot behind the result register.
//  Reset (synchronous, rst high) selects no checksum, restarts the sums and clears the emitter's flags and index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "selectable_checksum_engine_defines.svh"

module selectable_checksum_engine
  import csum_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] full_value
);

  logic [3:0]   algorithm_select;
  logic [31:0]  main_acc;
  logic [15:0]  second_sum;
  logic [31:0]  acc_next;
  logic [15:0]  sum_next;
  result_desc_t desc;
  logic         emits;
  emit_status_t status;
  logic         cfg_wr;
  logic         in_fire;
  logic         item_hold;
  logic         item_close;
  logic         restart_ok;
  logic [47:0]  acc_pair;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[1:0] <= 2'd3);
  assign prdata   = {28'h0, algorithm_select};
  assign in_ready = !status.pend_full;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm_select <= ALG_NONE;
      main_acc         <= start_value(ALG_NONE);
      second_sum       <= 16'h0;
    end else if (cfg_wr) begin
      algorithm_select <= pwdata[3:0];
      main_acc         <= start_value(pwdata[3:0]);
      second_sum       <= 16'h0;
    end else if (in_fire) begin
      if (last_byte) begin
        main_acc   <= start_value(algorithm_select);
        second_sum <= 16'h0;
      end else begin
        main_acc   <= acc_next;
        second_sum <= sum_next;
      end
    end
  end

  csum_update u_update (
    .sel        (algorithm_select),
    .main_acc   (main_acc),
    .second_sum (second_sum),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .acc_next   (acc_next),
    .sum_next   (sum_next),
    .desc       (desc),
    .emits      (emits)
  );

  csum_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire && last_byte && emits),
    .load_desc  (desc),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .full_value (full_value)
  );

  assign item_hold  = in_fire && !has_byte && !last_byte && !cfg_wr;
  assign item_close = in_fire && last_byte && !cfg_wr;
  assign restart_ok = (second_sum == 16'h0) && (main_acc == start_value(algorithm_select));
  assign acc_pair   = {main_acc, second_sum};

  `CSUM_ASSERT_NOW(a_pend_behind, status.pend_full, out_valid, "pending slot without result")
  `CSUM_ASSERT_NEXT(a_empty_holds, item_hold, $stable(acc_pair), "empty item changed sums")
  `CSUM_ASSERT_NEXT(a_restart_on_last, item_close, restart_ok, "accumulators not restarted")

endmodule

### src/csum_update.sv
// ---------------------------------------------------------------------------
// Checksum update
// Byte-wise accumulator update for every algorithm and result packing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csum_update
  import csum_pkg::*;
(
  input  logic [3:0]   sel,
  input  logic [31:0]  main_acc,
  input  logic [15:0]  second_sum,
  input  logic [7:0]   data_byte,
  input  logic         has_byte,
  output logic [31:0]  acc_next,
  output logic [15:0]  sum_next,
  output result_desc_t desc,
  output logic         emits
);

  function automatic logic [7:0] crc8_step(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    c = a ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] modbus_step(input logic [15:0] a, input logic [7:0] b);
    logic [15:0] c;
    c = a ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[15:1]} ^ 16'hA001) : {1'b0, c[15:1]};
    end
    return c;
  endfunction

  function automatic logic [15:0] ccitt_step(input logic [15:0] a, input logic [7:0] b);
    logic [15:0] c;
    c = a ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_step(input logic [31:0] a, input logic [7:0] b);
    logic [31:0] c;
    c = a ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ 32'hEDB8_8320) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] a, input logic [7:0] b);
    logic [7:0] x;
    x = a[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {a[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

  logic [16:0] modulus;
  logic [16:0] s1;
  logic [16:0] s2;
  logic [31:0] upd_acc;
  logic [15:0] upd_sum;

  assign modulus = (sel == ALG_ADLER32) ? ADLER_MOD : FLETCHER_MOD;

  always_comb begin
    s1 = {1'b0, main_acc[15:0]} + {9'h000, data_byte};
    if (s1 >= modulus) begin
      s1 = s1 - modulus;
    end
    s2 = {1'b0, second_sum} + s1;
    if (s2 >= modulus) begin
      s2 = s2 - modulus;
    end
  end

  always_comb begin
    upd_acc = main_acc;
    upd_sum = second_sum;
    case (sel)
      ALG_XOR8:   upd_acc = {24'h0, main_acc[7:0] ^ data_byte};
      ALG_MOD256: upd_acc = {24'h0, main_acc[7:0] + data_byte};
      ALG_CRC8:   upd_acc = {24'h0, crc8_step(main_acc[7:0], data_byte)};
      ALG_CRC16:  upd_acc = {16'h0, crc16_step(main_acc[15:0], data_byte)};
      ALG_MODBUS: upd_acc = {16'h0, modbus_step(main_acc[15:0], data_byte)};
      ALG_CCITT:  upd_acc = {16'h0, ccitt_step(main_acc[15:0], data_byte)};
      ALG_CRC32:  upd_acc = crc32_step(main_acc, data_byte);
      ALG_FLETCHER16, ALG_ADLER32: begin
        upd_acc = {16'h0, s1[15:0]};
        upd_sum = s2[15:0];
      end
      default: begin
        upd_acc = main_acc;
        upd_sum = second_sum;
      end
    endcase
  end

  assign acc_next = has_byte ? upd_acc : main_acc;
  assign sum_next = has_byte ? upd_sum : second_sum;

  always_comb begin
    desc.value  = 32'h0;
    desc.len    = 2'd0;
    desc.little = 1'b0;
    emits       = 1'b1;
    case (sel)
      ALG_XOR8, ALG_MOD256, ALG_CRC8: desc.value = {24'h0, acc_next[7:0]};
      ALG_CRC16, ALG_CCITT: begin
        desc.value = {16'h0, acc_next[15:0]};
        desc.len   = 2'd1;
      end
      ALG_MODBUS: begin
        desc.value  = {16'h0, acc_next[15:0]};
        desc.len    = 2'd1;
        desc.little = 1'b1;
      end
      ALG_FLETCHER16: begin
        desc.value = {16'h0, sum_next[7:0], acc_next[7:0]};
        desc.len   = 2'd1;
      end
      ALG_CRC32: begin
        desc.value = ~acc_next;
        desc.len   = 2'd3;
      end
      ALG_ADLER32: begin
        desc.value = {sum_next, acc_next[15:0]};
        desc.len   = 2'd3;
      end
      default: emits = 1'b0;
    endcase
  end

endmodule

### src/csum_emitter.sv
// ---------------------------------------------------------------------------
// Checksum emitter
// Result register plus one pending slot; sends packed bytes in wire order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csum_emitter
  import csum_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  result_desc_t load_desc,
  output emit_status_t status,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_byte,
  output logic         out_last,
  output logic [31:0]  full_value
);

  result_desc_t cur;
  result_desc_t pend;
  logic         pend_valid;
  logic [1:0]   idx;
  logic [1:0]   pos;
  logic         finish;

  assign finish = out_valid && out_ready && (idx == cur.len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (finish || !out_valid) begin
        idx <= 2'd0;
        if (pend_valid) begin
          cur        <= pend;
          out_valid  <= 1'b1;
          pend_valid <= 1'b0;
        end else if (load) begin
          cur       <= load_desc;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else begin
        if (out_ready) begin
          idx <= idx + 2'd1;
        end
        if (load) begin
          pend       <= load_desc;
          pend_valid <= 1'b1;
        end
      end
    end
  end

  assign pos = cur.little ? idx : (cur.len - idx);

  always_comb begin
    case (pos)
      2'd0:    out_byte = cur.value[7:0];
      2'd1:    out_byte = cur.value[15:8];
      2'd2:    out_byte = cur.value[23:16];
      default: out_byte = cur.value[31:24];
    endcase
  end

  assign out_last         = (idx == cur.len);
  assign full_value       = cur.value;
  assign status.pend_full = pend_valid;

endmodule
